FILE: rtl/ptsb_pkg.sv
// ptsb_pkg: shared widths, codes and controller/datapath structs for the
// periodic timer slot bank. No dependencies.
`default_nettype none

package ptsb_pkg;

    localparam int SlotCountDefault = 8;
    localparam int ValueWidth       = 20;
    localparam int StepWidth        = 10;
    localparam int IndexWidth       = 3;
    localparam int AddrSlots        = 1 << IndexWidth;

    localparam logic [StepWidth-1:0] TickStepReset = StepWidth'(50);

    typedef enum logic [1:0] {
        ACT_TICK = 2'd0,
        ACT_SET  = 2'd1,
        ACT_READ = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    typedef enum logic {
        KIND_FIRE = 1'b0,
        KIND_READ = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic                  in_ready;
        logic                  scan_step;
        logic                  emit_read;
        logic [IndexWidth-1:0] scan_idx;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic    in_valid;
        t_action in_action;
        logic    slot_fire;
        logic    out_free;
    } t_stat;

endpackage

`default_nettype wire

FILE: rtl/ptsb_if.sv
// ptsb_if: valid/ready channel interfaces for the input items, the results
// and the tick step register write. Depends on ptsb_pkg.
`default_nettype none

interface ptsb_in_if;
    import ptsb_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [1:0]            action;
    logic [IndexWidth-1:0] slot_index;
    logic [ValueWidth-1:0] interval_ms;
    logic                  enable_slot;

    modport source (output valid, action, slot_index, interval_ms, enable_slot,
                    input ready);
    modport sink   (input valid, action, slot_index, interval_ms, enable_slot,
                    output ready);
endinterface

interface ptsb_out_if;
    import ptsb_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [IndexWidth-1:0] slot_number;
    logic                  result_kind;
    logic [ValueWidth-1:0] timeout_value;
    logic                  last_result;

    modport source (output valid, slot_number, result_kind, timeout_value,
                    last_result, input ready);
    modport sink   (input valid, slot_number, result_kind, timeout_value,
                    last_result, output ready);
endinterface

interface ptsb_cfg_if;
    import ptsb_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [StepWidth-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/ptsb_ctrl.sv
// ptsb_ctrl: sequencer for the slot bank; walks the slots on a tick and
// paces the read answer. Depends on ptsb_pkg.
`default_nettype none

module ptsb_ctrl #(
    parameter int SLOT_COUNT = ptsb_pkg::SlotCountDefault
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ptsb_pkg::t_stat i_stat,
    output ptsb_pkg::t_cmd  o_cmd
);
    import ptsb_pkg::*;

    localparam int Store = (SLOT_COUNT < AddrSlots) ? SLOT_COUNT : AddrSlots;
    localparam int Sw    = (Store > 1) ? $clog2(Store) : 1;
    localparam logic [Sw-1:0] LastIdx = Sw'(Store - 1);

    t_state        r_state, n_state;
    logic [Sw-1:0] r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state         = r_state;
        n_idx           = r_idx;
        o_cmd.in_ready  = 1'b0;
        o_cmd.scan_step = 1'b0;
        o_cmd.emit_read = 1'b0;
        o_cmd.scan_idx  = IndexWidth'(r_idx);
        case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                n_idx          = '0;
                if (i_stat.in_valid) begin
                    case (i_stat.in_action)
                        ACT_TICK: n_state = ST_SCAN;
                        ACT_READ: n_state = ST_READ;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN: begin
                // a firing slot waits for room in the output register
                o_cmd.scan_step = !(i_stat.slot_fire && !i_stat.out_free);
                if (o_cmd.scan_step) begin
                    if (r_idx == LastIdx) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            ST_READ: begin
                o_cmd.emit_read = i_stat.out_free;
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/ptsb_datapath.sv
// ptsb_datapath: slot store, tick step register, fire mask and result
// register of the slot bank. Depends on ptsb_pkg and ptsb_if.
`default_nettype none

module ptsb_datapath #(
    parameter int SLOT_COUNT = ptsb_pkg::SlotCountDefault
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ptsb_in_if.sink         i_in,
    ptsb_out_if.source      o_out,
    ptsb_cfg_if.sink        i_cfg,
    input  ptsb_pkg::t_cmd  i_cmd,
    output ptsb_pkg::t_stat o_stat
);
    import ptsb_pkg::*;

    localparam int Store = (SLOT_COUNT < AddrSlots) ? SLOT_COUNT : AddrSlots;
    localparam int Sw    = (Store > 1) ? $clog2(Store) : 1;
    localparam logic [IndexWidth:0] StoreLim = (IndexWidth + 1)'(Store);

    logic [StepWidth-1:0]  r_step;
    logic [ValueWidth-1:0] r_timeout  [Store];
    logic [ValueWidth-1:0] r_interval [Store];
    logic [Store-1:0]      r_enabled;
    logic [Store-1:0]      r_fire;
    logic [IndexWidth-1:0] r_sel;

    logic                  r_out_valid;
    logic [IndexWidth-1:0] r_out_slot;
    t_kind                 r_out_kind;
    logic [ValueWidth-1:0] r_out_value;
    logic                  r_out_last;

    logic                  w_capture;
    logic                  w_set;
    logic                  w_rd_hit;
    logic                  w_emit_fire;
    logic                  w_out_free;
    logic                  w_last;
    logic [Sw-1:0]         w_idx;
    logic [Sw-1:0]         w_addr;
    logic [ValueWidth-1:0] w_step_ext;
    logic [Store-1:0]      w_fire_now;

    assign w_capture  = i_in.valid && i_cmd.in_ready;
    assign w_set      = w_capture && (t_action'(i_in.action) == ACT_SET)
                        && ({1'b0, i_in.slot_index} < StoreLim);
    assign w_rd_hit   = {1'b0, r_sel} < StoreLim;
    assign w_idx      = i_cmd.scan_idx[Sw-1:0];
    // one address into the store: the set slot, the read slot or the scan slot
    assign w_addr     = w_capture ? i_in.slot_index[Sw-1:0] :
                        (i_cmd.emit_read ? r_sel[Sw-1:0] : w_idx);
    assign w_step_ext = {{(ValueWidth - StepWidth){1'b0}}, r_step};
    assign w_emit_fire = i_cmd.scan_step && r_fire[w_addr];
    assign w_out_free = !r_out_valid || o_out.ready;

    always_comb begin
        for (int i = 0; i < Store; i++) begin
            w_fire_now[i] = r_enabled[i] && (r_timeout[i] <= w_step_ext);
        end
    end

    // final fire of the tick when no later slot is marked to fire
    always_comb begin
        w_last = 1'b1;
        for (int j = 0; j < Store; j++) begin
            if ((j > int'(w_idx)) && r_fire[j]) begin
                w_last = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= TickStepReset;
            r_enabled   <= '0;
            r_fire      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < Store; i++) begin
                r_timeout[i]  <= '0;
                r_interval[i] <= '0;
            end
        end else begin
            if (i_cfg.valid) begin
                r_step <= i_cfg.data;
            end
            if (w_capture) begin
                r_sel  <= i_in.slot_index;
                r_fire <= w_fire_now;
            end
            if (w_set) begin
                r_timeout[w_addr]  <= i_in.interval_ms;
                r_interval[w_addr] <= i_in.interval_ms;
                r_enabled[w_addr]  <= i_in.enable_slot;
            end else if (i_cmd.scan_step && r_enabled[w_addr]) begin
                if (r_fire[w_addr]) begin
                    r_timeout[w_addr] <= r_interval[w_addr];
                end else begin
                    r_timeout[w_addr] <= r_timeout[w_addr] - w_step_ext;
                end
            end
            if (w_emit_fire || i_cmd.emit_read) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit_fire) begin
            r_out_slot  <= IndexWidth'(w_addr);
            r_out_kind  <= KIND_FIRE;
            r_out_value <= r_interval[w_addr];
            r_out_last  <= w_last;
        end else if (i_cmd.emit_read) begin
            r_out_slot  <= r_sel;
            r_out_kind  <= KIND_READ;
            r_out_value <= w_rd_hit ? r_timeout[w_addr] : '0;
            r_out_last  <= 1'b1;
        end
    end

    assign i_in.ready          = i_cmd.in_ready;
    assign i_cfg.ready         = 1'b1;
    assign o_out.valid         = r_out_valid;
    assign o_out.slot_number   = r_out_slot;
    assign o_out.result_kind   = r_out_kind;
    assign o_out.timeout_value = r_out_value;
    assign o_out.last_result   = r_out_last;

    assign o_stat.in_valid  = i_in.valid;
    assign o_stat.in_action = t_action'(i_in.action);
    assign o_stat.slot_fire = r_fire[w_idx];
    assign o_stat.out_free  = w_out_free;

endmodule

`default_nettype wire

FILE: rtl/periodic_timer_slot_bank_core.sv
// A set writes its slot when taken; a read answers once the output register is
// free; a tick captures the fire mask and walks min(SLOT_COUNT, 8) slots at one
// slot per cycle, held while a firing slot's result cannot leave the output
// register. No new item is taken until a walk or read answer is done.
// Reset (synchronous, i_rst_n low): all slots disabled, store zeroed,
// tick step 50, no result pending.
`default_nettype none

module periodic_timer_slot_bank_core #(
    parameter int SLOT_COUNT = ptsb_pkg::SlotCountDefault
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ptsb_in_if.sink    i_in,
    ptsb_out_if.source o_out,
    ptsb_cfg_if.sink   i_cfg
);
    import ptsb_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    ptsb_ctrl #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_stat (w_stat),
        .o_cmd  (w_cmd)
    );

    ptsb_datapath #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_datapath (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (i_in),
        .o_out  (o_out),
        .i_cfg  (i_cfg),
        .i_cmd  (w_cmd),
        .o_stat (w_stat)
    );

endmodule

`default_nettype wire

FILE: rtl/ptsb_checker.sv
// ptsb_checker: port level assertions for the slot bank, bound to the
// top level. Depends on ptsb_pkg and periodic_timer_slot_bank_core.
`default_nettype none

module ptsb_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            i_in_ready,
    input logic [1:0]                      i_in_action,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [ptsb_pkg::IndexWidth-1:0] i_out_slot,
    input logic                            i_out_kind,
    input logic [ptsb_pkg::ValueWidth-1:0] i_out_value,
    input logic                            i_out_last
);
    import ptsb_pkg::*;

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_slot)
        && $stable(i_out_kind) && $stable(i_out_value) && $stable(i_out_last))
        else $error("result changed while stalled");

    a_read_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == KIND_READ) |-> i_out_last)
        else $error("read answer without last flag");

    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (t_action'(i_in_action) == ACT_READ)
        |=> !i_in_ready)
        else $error("input taken while read answer pending");

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (t_action'(i_in_action) == ACT_TICK)
        |=> !i_in_ready)
        else $error("input taken during slot walk");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("bad state after reset");

endmodule

bind periodic_timer_slot_bank_core ptsb_checker u_ptsb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in.valid),
    .i_in_ready (i_in.ready),
    .i_in_action(i_in.action),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_out_slot (o_out.slot_number),
    .i_out_kind (o_out.result_kind),
    .i_out_value(o_out.timeout_value),
    .i_out_last (o_out.last_result)
);

`default_nettype wire

FILE: sim/tb_ptsb_sb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the periodic timer slot bank bench: keeps its own copy of the
// slot store and tick step, predicts fire and read results and checks them in
// order. Depends on ptsb_pkg.
package tb_ptsb_sb_pkg;
    import ptsb_pkg::*;

    typedef struct {
        logic [IndexWidth-1:0] slot;
        t_kind                 kind;
        logic [ValueWidth-1:0] value;
        logic                  last;
    } t_slot_result;

    class t_slot_bank_scoreboard;
        logic [StepWidth-1:0]  step_ms;
        logic [ValueWidth-1:0] timeout_ms [SlotCountDefault];
        logic [ValueWidth-1:0] reload_ms  [SlotCountDefault];
        logic                  active     [SlotCountDefault];
        t_slot_result          expected_results [$];
        int                    errors;
        int                    fires_seen;
        int                    reads_seen;
        int                    items_seen;

        function new();
            step_ms = TickStepReset;
            foreach (timeout_ms[i]) begin
                timeout_ms[i] = '0;
                reload_ms[i]  = '0;
                active[i]     = 1'b0;
            end
            errors     = 0;
            fires_seen = 0;
            reads_seen = 0;
            items_seen = 0;
        endfunction

        function void write_step(logic [StepWidth-1:0] v);
            step_ms = v;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // called for every input transfer
        function void note_item(t_action act, logic [IndexWidth-1:0] idx,
                                logic [ValueWidth-1:0] ival, logic en);
            logic [SlotCountDefault-1:0] firing;
            int                          last_slot;
            t_slot_result                r;
            items_seen++;
            case (act)
                ACT_TICK: begin
                    firing    = '0;
                    last_slot = -1;
                    for (int i = 0; i < SlotCountDefault; i++) begin
                        if (active[i]) begin
                            // fires when the count-down would reach zero or below
                            if (timeout_ms[i] <= ValueWidth'(step_ms)) begin
                                firing[i]     = 1'b1;
                                timeout_ms[i] = reload_ms[i];
                                last_slot     = i;
                            end else begin
                                timeout_ms[i] = timeout_ms[i] - ValueWidth'(step_ms);
                            end
                        end
                    end
                    for (int i = 0; i < SlotCountDefault; i++) begin
                        if (firing[i]) begin
                            r.slot  = IndexWidth'(i);
                            r.kind  = KIND_FIRE;
                            r.value = reload_ms[i];
                            r.last  = (i == last_slot);
                            expected_results.push_back(r);
                        end
                    end
                end
                ACT_SET: begin
                    if (idx < SlotCountDefault) begin
                        timeout_ms[idx] = ival;
                        reload_ms[idx]  = ival;
                        active[idx]     = en;
                    end
                end
                ACT_READ: begin
                    r.slot  = idx;
                    r.kind  = KIND_READ;
                    r.value = (idx < SlotCountDefault) ? timeout_ms[idx] : '0;
                    r.last  = 1'b1;
                    expected_results.push_back(r);
                end
                default: ;
            endcase
        endfunction

        // called for every output transfer
        function void check_result(logic [IndexWidth-1:0] slot, logic kind,
                                   logic [ValueWidth-1:0] value, logic last);
            t_slot_result e;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected: slot %0d kind %0d value %0d last %0d",
                         $time, slot, kind, value, last);
                return;
            end
            e = expected_results.pop_front();
            if (e.kind == KIND_READ)
                reads_seen++;
            else
                fires_seen++;
            if (slot !== e.slot) begin
                errors++;
                $display("%0t: slot_number expected %0d actual %0d", $time, e.slot, slot);
            end
            if (kind !== e.kind) begin
                errors++;
                $display("%0t: result_kind expected %0d actual %0d", $time, e.kind, kind);
            end
            if (value !== e.value) begin
                errors++;
                $display("%0t: timeout_value (slot %0d) expected %0d actual %0d",
                         $time, e.slot, e.value, value);
            end
            if (last !== e.last) begin
                errors++;
                $display("%0t: last_result (slot %0d) expected %0d actual %0d",
                         $time, e.slot, e.last, last);
            end
        endfunction
    endclass

endpackage

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// Top of the periodic timer slot bank bench: drives ticks, sets and reads with
// random idling on both sides and checks every result through the scoreboard.
// Depends on ptsb_pkg, the ptsb channel interfaces and tb_ptsb_sb_pkg.
module tb_top;
    import ptsb_pkg::*;
    import tb_ptsb_sb_pkg::*;

    localparam int DrainCycles   = 24;
    localparam int ItemsPerPhase = 72;
    localparam int HoldCycles    = 300;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ptsb_in_if  in_if ();
    ptsb_out_if out_if ();
    ptsb_cfg_if cfg_if ();

    periodic_timer_slot_bank_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    t_slot_bank_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_reqs  = 0;
    int hold_seen  = 0;
    int hold_left  = 0;
    int step_writes = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // result side: check each transfer, then pick ready for the next edge
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_result(out_if.slot_number, out_if.result_kind,
                            out_if.timeout_value, out_if.last_result);
        if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = HoldCycles;
        end
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic send_item(t_action act, logic [IndexWidth-1:0] idx,
                             logic [ValueWidth-1:0] ival, logic en);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_if.valid       <= 1'b1;
        in_if.action      <= act;
        in_if.slot_index  <= idx;
        in_if.interval_ms <= ival;
        in_if.enable_slot <= en;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_item(act, idx, ival, en);
    endtask

    // a tick with no firing slot gives no result, so allow the walk to finish
    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_tick_step(logic [StepWidth-1:0] v);
        drain_results();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        sb.write_step(v);
        step_writes++;
    endtask

    initial begin
        logic [StepWidth-1:0]  step;
        logic [ValueWidth-1:0] ival;
        t_action               act;
        int                    r;
        sb = new();
        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.action      = ACT_TICK;
        in_if.slot_index  = '0;
        in_if.interval_ms = '0;
        in_if.enable_slot = 1'b0;
        out_if.ready      = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.data       = '0;
        send_idle_pct     = 12;
        recv_idle_pct     = 73;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at the reset tick step
        send_item(ACT_READ, 3'd0, '0, 1'b0);
        send_item(ACT_READ, 3'd7, '1, 1'b1);
        send_item(ACT_NONE, 3'd5, 20'h5a5a5, 1'b1);
        send_item(ACT_SET, 3'd0, '0, 1'b1);        // zero interval fires every tick
        send_item(ACT_SET, 3'd1, 20'd50, 1'b1);    // equal to the step
        send_item(ACT_SET, 3'd2, 20'd51, 1'b1);
        send_item(ACT_SET, 3'd3, 20'd100, 1'b0);   // written but not counting
        send_item(ACT_SET, 3'd7, '1, 1'b1);
        send_item(ACT_TICK, 3'd0, '0, 1'b0);
        send_item(ACT_TICK, 3'd7, '1, 1'b1);
        send_item(ACT_READ, 3'd1, '0, 1'b0);
        send_item(ACT_READ, 3'd2, '0, 1'b0);
        send_item(ACT_READ, 3'd3, '0, 1'b0);
        send_item(ACT_READ, 3'd7, '0, 1'b0);
        send_item(ACT_SET, 3'd2, '0, 1'b0);
        send_item(ACT_TICK, 3'd2, 20'hfffff, 1'b0);
        send_item(ACT_READ, 3'd2, '0, 1'b0);
        send_item(ACT_NONE, 3'd2, '0, 1'b0);

        // every slot fires on every tick while the receiver holds off
        for (int s = 0; s < SlotCountDefault; s++)
            send_item(ACT_SET, IndexWidth'(s), '0, 1'b1);
        hold_reqs <= hold_reqs + 1;
        repeat (12) send_item(ACT_TICK, IndexWidth'($urandom), ValueWidth'($urandom), 1'b1);

        for (int p = 0; p < 6; p++) begin
            case (p)
                0:       step = '0;
                1:       step = '1;
                2:       step = 10'd1;
                3:       step = TickStepReset;
                default: step = StepWidth'($urandom_range(1, 1023));
            endcase
            write_tick_step(step);
            if (p < 2) begin
                send_idle_pct = 12;
                recv_idle_pct <= 73;
            end else if (p < 4) begin
                send_idle_pct = 73;
                recv_idle_pct <= 12;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            repeat (ItemsPerPhase) begin
                r = $urandom_range(0, 99);
                if (r < 40)
                    act = ACT_TICK;
                else if (r < 70)
                    act = ACT_SET;
                else if (r < 95)
                    act = ACT_READ;
                else
                    act = ACT_NONE;
                // mostly intervals a few steps long so slots fire often
                r = $urandom_range(0, 9);
                if (r < 6)
                    ival = ValueWidth'(step * $urandom_range(0, 6) + $urandom_range(0, 3));
                else if (r < 8)
                    ival = ValueWidth'($urandom_range(0, 50));
                else
                    ival = ValueWidth'($urandom);
                send_item(act, IndexWidth'($urandom_range(0, 7)), ival,
                          $urandom_range(0, 9) < 8);
            end
        end

        drain_results();
        $display("%0d items in, %0d fire and %0d read results checked, %0d tick step writes",
                 sb.items_seen, sb.fires_seen, sb.reads_seen, step_writes);
        $display("idle mixes 12/73, 73/12 and none, plus one long receiver hold-off");
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("timeout: results still outstanding");
        $display("Some tests failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/ptsb_pkg.sv
rtl/ptsb_if.sv
rtl/ptsb_ctrl.sv
rtl/ptsb_datapath.sv
rtl/periodic_timer_slot_bank_core.sv
rtl/ptsb_checker.sv
sim/tb_ptsb_sb_pkg.sv
sim/tb_top.sv
